/* design/qrs_pkg.sv */
// qrs_pkg: shared constants, register codes, controller states and the
// command/status structs of the qr module raster scaler
// no dependencies
package qrs_pkg;

  // default sizing for the top level parameters
  localparam int DEF_MODULE_DEPTH = 32768;
  localparam int DEF_COORD_BITS   = 12;

  // fixed field widths
  localparam int FRAME_BITS     = 12;
  localparam int SCALE_BITS     = 8;
  localparam int SPAN_BITS      = 16;
  localparam int INDEX_BITS     = 15;
  localparam int PIXEL_BITS     = 8;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 12;

  // grey levels
  localparam logic [PIXEL_BITS-1:0] PIX_DARK  = 8'h00;
  localparam logic [PIXEL_BITS-1:0] PIX_LIGHT = 8'hff;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_QR_WIDTH      = 3'd2,
    REG_MODULE_SCALE  = 3'd3,
    REG_ALIGNMENT     = 3'd4,
    REG_INVERT_COLORS = 3'd5,
    REG_CIPHER_MODE   = 3'd6,
    REG_FRAME_REPEATS = 3'd7
  } cfg_reg_t;

  // register reset values
  localparam logic [FRAME_BITS-1:0] RST_FRAME_WIDTH   = 12'd640;
  localparam logic [FRAME_BITS-1:0] RST_FRAME_HEIGHT  = 12'd480;
  localparam logic [7:0]            RST_QR_WIDTH      = 8'd21;
  localparam logic [7:0]            RST_MODULE_SCALE  = 8'd1;
  localparam logic [7:0]            RST_ALIGNMENT     = 8'd0;
  localparam logic [7:0]            RST_FRAME_REPEATS = 8'd1;

  // cipher modes
  localparam logic [1:0] CIPHER_OFF  = 2'd0;
  localparam logic [1:0] CIPHER_KEEP = 2'd1;

  // input operations
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EMIT = 1'b1;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LOAD_RD,
    ST_LOAD_WR,
    ST_PLACE_GO,
    ST_PLACE_DIV,
    ST_PLACE_MUL,
    ST_OFF_SET,
    ST_PIX_CHECK,
    ST_PIX_GO,
    ST_PIX_DIV,
    ST_PIX_MUL,
    ST_PIX_RD,
    ST_PIX_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;    // latch the accepted input transaction
    logic key_rd;     // read key store at the load index
    logic mod_wr;     // write module store (and key store) for a load
    logic div_go;     // start both divider lanes
    logic div_pix;    // divider operands: 1 pixel offsets by scale, 0 slack by alignment
    logic place_mul;  // register half quotient times alignment
    logic off_set;    // latch frame offsets
    logic idx_mul;    // register row times code width
    logic mod_rd;     // read module store at the pixel's module
    logic emit;       // load the output register and step the raster
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op;
    logic need_xor;
    logic frame_start;
    logic align_zero;
    logic in_region;
    logic div_done;
    logic out_free;
  } ctrl_stat_t;

endpackage

/* design/qr_module_raster_scaler_core.sv */
// qr module raster scaler top level: a load writes the module store, after one key store
// read when the bit is xored with a stored key bit; an emit inside the code runs the
// bit-serial divider for module column and row, then reads the module store, while one
// outside the code goes straight to the output; the first pixel of a frame first snaps
// the offsets, running the divider unless alignment is zero; synchronous active-low reset
// clears counters, offsets and output valid, presets config registers; stores are not cleared
module qr_module_raster_scaler_core #(
  parameter int MODULE_DEPTH = qrs_pkg::DEF_MODULE_DEPTH,
  parameter int COORD_BITS   = qrs_pkg::DEF_COORD_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [qrs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [qrs_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  // input channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_op,
  input  logic [qrs_pkg::INDEX_BITS-1:0]     in_module_index,
  input  logic                               in_module_bit,
  input  logic                               in_key_frame,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [qrs_pkg::PIXEL_BITS-1:0]     out_pixel,
  output logic                               out_end_of_line,
  output logic                               out_end_of_frame,
  output logic                               out_end_of_burst
);

  qrs_pkg::ctrl_cmd_t  cmd;
  qrs_pkg::ctrl_stat_t stat;

  // configuration writes are always taken
  assign cfg_ready = 1'b1;

  // controller
  qrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  qrs_datapath #(
    .MODULE_DEPTH (MODULE_DEPTH),
    .COORD_BITS   (COORD_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_op            (in_op),
    .in_module_index  (in_module_index),
    .in_module_bit    (in_module_bit),
    .in_key_frame     (in_key_frame),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_pixel        (out_pixel),
    .out_end_of_line  (out_end_of_line),
    .out_end_of_frame (out_end_of_frame),
    .out_end_of_burst (out_end_of_burst),
    .cmd              (cmd),
    .stat             (stat)
  );

  // a result is only loaded when the output register frees up
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free)
    else $error("result loaded over a pending transaction");

  // once a transaction is taken the block is busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> !in_ready)
    else $error("input accepted while previous transaction in flight");

  // a divider start is never reported done on the next cycle
  a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_go |=> !stat.div_done)
    else $error("divider finished without iterating");

  // a module read is followed by the emit, unless the output is stalled
  a_read_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mod_rd |=> (cmd.emit || !stat.out_free))
    else $error("module read not followed by emit");

endmodule

/* design/qrs_div.sv */
// qrs_div: restoring divider, one quotient bit per cycle, 8-bit divisor
// depends on qrs_pkg for the divisor width
module qrs_div #(
  parameter int W = qrs_pkg::DEF_COORD_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [W-1:0]                   dividend,
  input  logic [qrs_pkg::SCALE_BITS-1:0] divisor,
  output logic [W-1:0]                   quotient,
  output logic                           done
);

  localparam int CNT_BITS = $clog2(W + 1);
  localparam int DV = qrs_pkg::SCALE_BITS;

  logic [W-1:0]        quo_r, quo_nxt;
  logic [DV-1:0]       rem_r, rem_nxt;
  logic [DV-1:0]       div_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic [DV:0]         trial;
  logic [DV:0]         diff;
  logic                fits;

  // one shift-subtract step
  always_comb begin
    trial   = {rem_r, quo_r[W-1]};
    fits    = trial >= {1'b0, div_r};
    diff    = trial - {1'b0, div_r};
    rem_nxt = fits ? diff[DV-1:0] : trial[DV-1:0];
    quo_nxt = {quo_r[W-2:0], fits};
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_BITS'(W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // operand and partial result registers
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (cnt_r != '0) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient = quo_r;
  assign done     = cnt_r == '0;

endmodule

/* design/qrs_ctrl.sv */
// qrs_ctrl: sequencing state machine for loads and pixel emission
// depends on qrs_pkg for states and the command/status structs
module qrs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  qrs_pkg::ctrl_stat_t stat,
  output qrs_pkg::ctrl_cmd_t  cmd
);

  qrs_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qrs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      qrs_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = qrs_pkg::ST_DECODE;
      end
      qrs_pkg::ST_DECODE: begin
        if (stat.op == qrs_pkg::OP_LOAD) begin
          state_nxt = stat.need_xor ? qrs_pkg::ST_LOAD_RD : qrs_pkg::ST_LOAD_WR;
        end else if (!stat.frame_start) begin
          state_nxt = qrs_pkg::ST_PIX_CHECK;
        end else begin
          state_nxt = stat.align_zero ? qrs_pkg::ST_OFF_SET : qrs_pkg::ST_PLACE_GO;
        end
      end
      qrs_pkg::ST_LOAD_RD:   state_nxt = qrs_pkg::ST_LOAD_WR;
      qrs_pkg::ST_LOAD_WR:   state_nxt = qrs_pkg::ST_IDLE;
      qrs_pkg::ST_PLACE_GO:  state_nxt = qrs_pkg::ST_PLACE_DIV;
      qrs_pkg::ST_PLACE_DIV: begin
        if (stat.div_done) state_nxt = qrs_pkg::ST_PLACE_MUL;
      end
      qrs_pkg::ST_PLACE_MUL: state_nxt = qrs_pkg::ST_OFF_SET;
      qrs_pkg::ST_OFF_SET:   state_nxt = qrs_pkg::ST_PIX_CHECK;
      qrs_pkg::ST_PIX_CHECK: begin
        state_nxt = stat.in_region ? qrs_pkg::ST_PIX_GO : qrs_pkg::ST_PIX_OUT;
      end
      qrs_pkg::ST_PIX_GO:    state_nxt = qrs_pkg::ST_PIX_DIV;
      qrs_pkg::ST_PIX_DIV: begin
        if (stat.div_done) state_nxt = qrs_pkg::ST_PIX_MUL;
      end
      qrs_pkg::ST_PIX_MUL:   state_nxt = qrs_pkg::ST_PIX_RD;
      qrs_pkg::ST_PIX_RD:    state_nxt = qrs_pkg::ST_PIX_OUT;
      qrs_pkg::ST_PIX_OUT: begin
        if (stat.out_free) state_nxt = qrs_pkg::ST_IDLE;
      end
      default:               state_nxt = qrs_pkg::ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      qrs_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      qrs_pkg::ST_LOAD_RD:   cmd.key_rd = 1'b1;
      qrs_pkg::ST_LOAD_WR:   cmd.mod_wr = 1'b1;
      qrs_pkg::ST_PLACE_GO:  cmd.div_go = 1'b1;
      qrs_pkg::ST_PLACE_MUL: cmd.place_mul = 1'b1;
      qrs_pkg::ST_OFF_SET:   cmd.off_set = 1'b1;
      qrs_pkg::ST_PIX_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_pix = 1'b1;
      end
      qrs_pkg::ST_PIX_MUL:   cmd.idx_mul = 1'b1;
      qrs_pkg::ST_PIX_RD:    cmd.mod_rd = 1'b1;
      qrs_pkg::ST_PIX_OUT:   cmd.emit = stat.out_free;
      default:               cmd = '0;
    endcase
  end

endmodule

/* design/qrs_datapath.sv */
// qrs_datapath: configuration registers, module and key stores, offset and
// raster arithmetic, output register
// depends on qrs_pkg and qrs_div
module qrs_datapath #(
  parameter int MODULE_DEPTH = qrs_pkg::DEF_MODULE_DEPTH,
  parameter int COORD_BITS   = qrs_pkg::DEF_COORD_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_valid,
  input  logic [qrs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [qrs_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  // input payload
  input  logic                               in_op,
  input  logic [qrs_pkg::INDEX_BITS-1:0]     in_module_index,
  input  logic                               in_module_bit,
  input  logic                               in_key_frame,
  // output channel
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [qrs_pkg::PIXEL_BITS-1:0]     out_pixel,
  output logic                               out_end_of_line,
  output logic                               out_end_of_frame,
  output logic                               out_end_of_burst,
  // controller link
  input  qrs_pkg::ctrl_cmd_t                 cmd,
  output qrs_pkg::ctrl_stat_t                stat
);

  localparam int ADDR_BITS = $clog2(MODULE_DEPTH);
  localparam int DIV_BITS  = (COORD_BITS > qrs_pkg::FRAME_BITS) ? COORD_BITS
                                                                : qrs_pkg::FRAME_BITS;
  localparam int CMP_BITS  = DIV_BITS + 1;
  localparam int PROD_BITS = DIV_BITS + qrs_pkg::SCALE_BITS;
  localparam int SPAN_BITS = qrs_pkg::SPAN_BITS;
  localparam int FB        = qrs_pkg::FRAME_BITS;
  localparam int SB        = qrs_pkg::SCALE_BITS;

  // configuration registers
  logic [FB-1:0] fw_r, fh_r;
  logic [SB-1:0] qrw_r, scale_r, align_r, reps_r;
  logic          inv_r;
  logic [1:0]    mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r    <= qrs_pkg::RST_FRAME_WIDTH;
      fh_r    <= qrs_pkg::RST_FRAME_HEIGHT;
      qrw_r   <= qrs_pkg::RST_QR_WIDTH;
      scale_r <= qrs_pkg::RST_MODULE_SCALE;
      align_r <= qrs_pkg::RST_ALIGNMENT;
      inv_r   <= 1'b0;
      mode_r  <= qrs_pkg::CIPHER_OFF;
      reps_r  <= qrs_pkg::RST_FRAME_REPEATS;
    end else if (cfg_valid) begin
      case (cfg_index)
        qrs_pkg::REG_FRAME_WIDTH:   fw_r    <= cfg_data[FB-1:0];
        qrs_pkg::REG_FRAME_HEIGHT:  fh_r    <= cfg_data[FB-1:0];
        qrs_pkg::REG_QR_WIDTH:      qrw_r   <= cfg_data[SB-1:0];
        qrs_pkg::REG_MODULE_SCALE:  scale_r <= cfg_data[SB-1:0];
        qrs_pkg::REG_ALIGNMENT:     align_r <= cfg_data[SB-1:0];
        qrs_pkg::REG_INVERT_COLORS: inv_r   <= cfg_data[0];
        qrs_pkg::REG_CIPHER_MODE:   mode_r  <= cfg_data[1:0];
        qrs_pkg::REG_FRAME_REPEATS: reps_r  <= cfg_data[SB-1:0];
        default:                    inv_r   <= inv_r;
      endcase
    end
  end

  // captured input transaction
  logic                 op_r, bit_r, key_r;
  logic [ADDR_BITS-1:0] idx_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_op;
      idx_r <= in_module_index[ADDR_BITS-1:0];
      bit_r <= in_module_bit;
      key_r <= in_key_frame;
    end
  end

  // effective frame size, code span and slack
  logic [FB-1:0]        fw_eff, fh_eff;
  logic [SPAN_BITS-1:0] span_r;
  logic [FB-1:0]        slack_x, slack_y;

  always_ff @(posedge clk) begin
    span_r <= scale_r * qrw_r;
  end

  always_comb begin
    fw_eff  = (fw_r == '0) ? FB'(1) : fw_r;
    fh_eff  = (fh_r == '0) ? FB'(1) : fh_r;
    slack_x = (SPAN_BITS'(fw_eff) > span_r) ? FB'(SPAN_BITS'(fw_eff) - span_r) : '0;
    slack_y = (SPAN_BITS'(fh_eff) > span_r) ? FB'(SPAN_BITS'(fh_eff) - span_r) : '0;
  end

  // raster position and offsets
  logic [COORD_BITS-1:0] px_r, py_r, off_x_r, off_y_r;
  logic [SB-1:0]         rep_r;
  logic [COORD_BITS-1:0] dx, dy;
  logic                  in_region;

  always_comb begin
    dx        = px_r - off_x_r;
    dy        = py_r - off_y_r;
    in_region = (scale_r != '0) &&
                (px_r >= off_x_r) && (SPAN_BITS'(dx) < span_r) &&
                (py_r >= off_y_r) && (SPAN_BITS'(dy) < span_r);
  end

  // divider lanes, shared by offset placement and module lookup
  logic [DIV_BITS-1:0] div_a_x, div_a_y, quo_x, quo_y;
  logic [SB-1:0]       div_b;
  logic                done_x, done_y;

  always_comb begin
    div_a_x = cmd.div_pix ? DIV_BITS'(dx) : DIV_BITS'(slack_x);
    div_a_y = cmd.div_pix ? DIV_BITS'(dy) : DIV_BITS'(slack_y);
    div_b   = cmd.div_pix ? scale_r : align_r;
  end

  qrs_div #(.W(DIV_BITS)) u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_go),
    .dividend (div_a_x),
    .divisor  (div_b),
    .quotient (quo_x),
    .done     (done_x)
  );

  qrs_div #(.W(DIV_BITS)) u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_go),
    .dividend (div_a_y),
    .divisor  (div_b),
    .quotient (quo_y),
    .done     (done_y)
  );

  // snapped offset: half the slack when alignment is zero, else half the step count times the step, or one step
  logic [PROD_BITS-1:0] pprod_x_r, pprod_y_r;
  logic [DIV_BITS-1:0]  place_x, place_y;

  always_ff @(posedge clk) begin
    if (cmd.place_mul) begin
      pprod_x_r <= (quo_x >> 1) * align_r;
      pprod_y_r <= (quo_y >> 1) * align_r;
    end
  end

  always_comb begin
    if (align_r == '0) begin
      place_x = DIV_BITS'(slack_x) >> 1;
      place_y = DIV_BITS'(slack_y) >> 1;
    end else begin
      place_x = (quo_x == DIV_BITS'(1)) ? DIV_BITS'(align_r) : pprod_x_r[DIV_BITS-1:0];
      place_y = (quo_y == DIV_BITS'(1)) ? DIV_BITS'(align_r) : pprod_y_r[DIV_BITS-1:0];
    end
  end

  // end-of-line, frame and burst flags
  logic eol, eof, eob;

  always_comb begin
    eol = (CMP_BITS'(px_r) + 1'b1) >= CMP_BITS'(fw_eff);
    eof = eol && ((CMP_BITS'(py_r) + 1'b1) >= CMP_BITS'(fh_eff));
    eob = eof && (({1'b0, rep_r} + 1'b1) >=
                  ((reps_r == '0) ? 9'd1 : {1'b0, reps_r}));
  end

  // raster counters and latched offsets
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r    <= '0;
      py_r    <= '0;
      rep_r   <= '0;
      off_x_r <= '0;
      off_y_r <= '0;
    end else begin
      if (cmd.off_set) begin
        off_x_r <= place_x[COORD_BITS-1:0];
        off_y_r <= place_y[COORD_BITS-1:0];
      end
      if (cmd.emit) begin
        if (!eol) begin
          px_r <= px_r + 1'b1;
        end else begin
          px_r <= '0;
          if (!eof) begin
            py_r <= py_r + 1'b1;
          end else begin
            py_r  <= '0;
            rep_r <= eob ? '0 : rep_r + 1'b1;
          end
        end
      end
    end
  end

  // module address from row and column
  logic [SPAN_BITS-1:0] rowprod_r;
  logic [SB-1:0]        col_r;
  logic [SPAN_BITS-1:0] mod_sum;
  logic [ADDR_BITS-1:0] rd_addr;

  always_ff @(posedge clk) begin
    if (cmd.idx_mul) begin
      rowprod_r <= quo_y[SB-1:0] * qrw_r;
      col_r     <= quo_x[SB-1:0];
    end
  end

  assign mod_sum = rowprod_r + SPAN_BITS'(col_r);
  assign rd_addr = mod_sum[ADDR_BITS-1:0];

  // key store
  logic key_store [MODULE_DEPTH];
  logic key_rd_r;

  always_ff @(posedge clk) begin
    if (cmd.mod_wr && (mode_r != qrs_pkg::CIPHER_OFF) && key_r) begin
      key_store[idx_r] <= bit_r;
    end
    if (cmd.key_rd) begin
      key_rd_r <= key_store[idx_r];
    end
  end

  // module store
  logic module_store [MODULE_DEPTH];
  logic mod_bit_r;
  logic mod_wdata;

  always_comb begin
    if (mode_r == qrs_pkg::CIPHER_OFF) begin
      mod_wdata = bit_r;
    end else if (key_r) begin
      mod_wdata = (mode_r == qrs_pkg::CIPHER_KEEP) ? bit_r : 1'b0;
    end else begin
      mod_wdata = bit_r ^ key_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mod_wr) begin
      module_store[idx_r] <= mod_wdata;
    end
    if (cmd.mod_rd) begin
      mod_bit_r <= module_store[rd_addr];
    end
  end

  // pixel colour
  logic [qrs_pkg::PIXEL_BITS-1:0] draw, pix;

  always_comb begin
    draw = inv_r ? qrs_pkg::PIX_LIGHT : qrs_pkg::PIX_DARK;
    pix  = (in_region && mod_bit_r) ? draw : ~draw;
  end

  // output register
  logic                           out_valid_r;
  logic [qrs_pkg::PIXEL_BITS-1:0] pix_r;
  logic                           eol_r, eof_r, eob_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pix_r <= pix;
      eol_r <= eol;
      eof_r <= eof;
      eob_r <= eob;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel        = pix_r;
  assign out_end_of_line  = eol_r;
  assign out_end_of_frame = eof_r;
  assign out_end_of_burst = eob_r;

  // status to the controller
  always_comb begin
    stat.op          = op_r;
    stat.need_xor    = (mode_r != qrs_pkg::CIPHER_OFF) && !key_r;
    stat.frame_start = (px_r == '0) && (py_r == '0);
    stat.align_zero  = align_r == '0;
    stat.in_region   = in_region;
    stat.div_done    = done_x && done_y;
    stat.out_free    = !out_valid_r || out_ready;
  end

endmodule

/* verif/qrs_raster_checker.sv */
// qrs_raster_checker: watches the configuration, input and pixel channels of the
// raster scaler, predicts every pixel transaction and compares them in order
// depends on qrs_pkg for register codes, operations, cipher modes and grey levels
module qrs_raster_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [qrs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [qrs_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic                               in_op,
  input  logic [qrs_pkg::INDEX_BITS-1:0]     in_module_index,
  input  logic                               in_module_bit,
  input  logic                               in_key_frame,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [qrs_pkg::PIXEL_BITS-1:0]     out_pixel,
  input  logic                               out_end_of_line,
  input  logic                               out_end_of_frame,
  input  logic                               out_end_of_burst,
  output int                                 mismatches,
  output int                                 outstanding
);
  import qrs_pkg::*;

  localparam int STORE_DEPTH  = DEF_MODULE_DEPTH;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel;
    logic                  eol;
    logic                  eof;
    logic                  eob;
  } raster_beat_t;

  // shadow of the code and key stores
  logic module_bits [0:STORE_DEPTH-1];
  logic key_bits    [0:STORE_DEPTH-1];

  // shadow raster position and latched code origin
  logic [FRAME_BITS-1:0] pos_x, pos_y, org_x, org_y;
  logic [7:0]            burst_frame;

  // shadow registers
  logic [FRAME_BITS-1:0] width_r, height_r;
  logic [7:0]            qr_r, scale_r, align_r, repeats_r;
  logic                  invert_r;
  logic [1:0]            cipher_r;

  raster_beat_t expected_pixels [$];
  int           miss_count;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // code origin along one axis: centred, or snapped to the alignment step
  function automatic logic [FRAME_BITS-1:0] snap_offset(input int frame, input int span);
    int slack, steps;
    slack = frame - span;
    if (slack < 0) slack = 0;
    if (align_r == 0) return FRAME_BITS'(slack / 2);
    steps = slack / int'(align_r);
    if (steps == 1) return FRAME_BITS'(align_r);
    return FRAME_BITS'((steps / 2) * int'(align_r));
  endfunction

  always @(posedge clk) begin
    raster_beat_t want, got;
    int fw, fh, reps, span, px, py, ox, oy, idx;
    logic [PIXEL_BITS-1:0] ink;

    if (!rst_n) begin
      pos_x       = '0;
      pos_y       = '0;
      org_x       = '0;
      org_y       = '0;
      burst_frame = '0;
      width_r     = RST_FRAME_WIDTH;
      height_r    = RST_FRAME_HEIGHT;
      qr_r        = RST_QR_WIDTH;
      scale_r     = RST_MODULE_SCALE;
      align_r     = RST_ALIGNMENT;
      invert_r    = 1'b0;
      cipher_r    = CIPHER_OFF;
      repeats_r   = RST_FRAME_REPEATS;
      expected_pixels.delete();
      miss_count  = 0;
    end else begin
      // register write transaction
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_FRAME_WIDTH:   width_r   = cfg_data[FRAME_BITS-1:0];
          REG_FRAME_HEIGHT:  height_r  = cfg_data[FRAME_BITS-1:0];
          REG_QR_WIDTH:      qr_r      = cfg_data[7:0];
          REG_MODULE_SCALE:  scale_r   = cfg_data[7:0];
          REG_ALIGNMENT:     align_r   = cfg_data[7:0];
          REG_INVERT_COLORS: invert_r  = cfg_data[0];
          REG_CIPHER_MODE:   cipher_r  = cfg_data[1:0];
          REG_FRAME_REPEATS: repeats_r = cfg_data[7:0];
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        if (in_op == OP_LOAD) begin
          // module load, with key capture or key xor when ciphering
          idx = int'(in_module_index);
          if (cipher_r == CIPHER_OFF) begin
            module_bits[idx] = in_module_bit;
          end else if (in_key_frame) begin
            key_bits[idx]    = in_module_bit;
            module_bits[idx] = (cipher_r > CIPHER_KEEP) ? 1'b0 : in_module_bit;
          end else begin
            module_bits[idx] = in_module_bit ^ key_bits[idx];
          end
        end else begin
          // next pixel of the raster
          fw   = (width_r == 0) ? 1 : int'(width_r);
          fh   = (height_r == 0) ? 1 : int'(height_r);
          reps = (repeats_r == 0) ? 1 : int'(repeats_r);
          span = int'(scale_r) * int'(qr_r);
          ink  = invert_r ? PIX_LIGHT : PIX_DARK;
          if (pos_x == 0 && pos_y == 0) begin
            org_x = snap_offset(fw, span);
            org_y = snap_offset(fh, span);
          end
          px = int'(pos_x);
          py = int'(pos_y);
          ox = int'(org_x);
          oy = int'(org_y);
          want.pixel = ~ink;
          if (scale_r != 0 && px >= ox && px - ox < span && py >= oy && py - oy < span) begin
            idx = (((py - oy) / int'(scale_r)) * int'(qr_r) + (px - ox) / int'(scale_r))
                  % STORE_DEPTH;
            if (module_bits[idx] === 1'b1) want.pixel = ink;
          end
          want.eol = (px + 1 >= fw);
          want.eof = want.eol && (py + 1 >= fh);
          want.eob = want.eof && (int'(burst_frame) + 1 >= reps);
          expected_pixels.push_back(want);

          // advance the raster
          if (!want.eol) begin
            pos_x = pos_x + 1'b1;
          end else begin
            pos_x = '0;
            if (!want.eof) begin
              pos_y = pos_y + 1'b1;
            end else begin
              pos_y       = '0;
              burst_frame = want.eob ? 8'd0 : burst_frame + 8'd1;
            end
          end
        end
      end

      // pixel transaction against the oldest prediction
      if (out_valid && out_ready) begin
        got.pixel = out_pixel;
        got.eol   = out_end_of_line;
        got.eof   = out_end_of_frame;
        got.eob   = out_end_of_burst;
        if (expected_pixels.size() == 0) begin
          if (miss_count < REPORT_LIMIT)
            $display("pixel transaction with none expected: pixel %02h eol %b eof %b eob %b",
                     got.pixel, got.eol, got.eof, got.eob);
          miss_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (got.pixel !== want.pixel || got.eol !== want.eol ||
              got.eof !== want.eof || got.eob !== want.eob) begin
            if (miss_count < REPORT_LIMIT)
              $display("pixel mismatch: expected %02h eol %b eof %b eob %b,",
                       want.pixel, want.eol, want.eof, want.eob,
                       " got %02h eol %b eof %b eob %b",
                       got.pixel, got.eol, got.eof, got.eob);
            miss_count++;
          end
        end
      end
    end

    mismatches  <= miss_count;
    outstanding <= expected_pixels.size();
  end

endmodule

/* verif/tb.sv */
// tb: stimulus and verdict for qr_module_raster_scaler_core
// fills the low end of both stores, runs directed corner cases, then random register
// settings with mixed loads and pixel requests; depends on qrs_pkg and qrs_raster_checker
module tb;
  import qrs_pkg::*;

  localparam int STORE_DEPTH   = DEF_MODULE_DEPTH;
  localparam int MAX_RAND_QR   = 25;
  localparam int FILL_DEPTH    = MAX_RAND_QR * MAX_RAND_QR;
  localparam int RANDOM_ITEMS  = 450;
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_WAIT      = 18;

  // cipher modes with no package name
  localparam logic [1:0] CIPHER_BLANK = 2'd2;
  localparam logic [1:0] CIPHER_SPARE = 2'd3;

  logic                      clk              = 1'b0;
  logic                      rst_n            = 1'b0;
  logic                      cfg_valid        = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index        = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data         = '0;
  logic                      in_valid         = 1'b0;
  logic                      in_ready;
  logic                      in_op            = OP_LOAD;
  logic [INDEX_BITS-1:0]     in_module_index  = '0;
  logic                      in_module_bit    = 1'b0;
  logic                      in_key_frame     = 1'b0;
  logic                      out_valid;
  logic                      out_ready        = 1'b0;
  logic [PIXEL_BITS-1:0]     out_pixel;
  logic                      out_end_of_line;
  logic                      out_end_of_frame;
  logic                      out_end_of_burst;

  int mismatches;
  int outstanding;
  int max_gap   = 0;
  int max_stall = 0;
  bit input_held = 1'b0;
  int cfg_plan [8];
  int cfg_now  [8] = '{640, 480, 21, 1, 0, 0, 0, 1};

  always #1 clk = ~clk;

  qr_module_raster_scaler_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_module_index  (in_module_index),
    .in_module_bit    (in_module_bit),
    .in_key_frame     (in_key_frame),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel        (out_pixel),
    .out_end_of_line  (out_end_of_line),
    .out_end_of_frame (out_end_of_frame),
    .out_end_of_burst (out_end_of_burst)
  );

  qrs_raster_checker u_watch (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_module_index  (in_module_index),
    .in_module_bit    (in_module_bit),
    .in_key_frame     (in_key_frame),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel        (out_pixel),
    .out_end_of_line  (out_end_of_line),
    .out_end_of_frame (out_end_of_frame),
    .out_end_of_burst (out_end_of_burst),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  // input transaction, valid kept high when the next one follows with no gap
  task automatic send_item(input logic op, input int idx, input logic dark, input logic is_key);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      if (input_held) in_valid <= 1'b0;
      input_held = 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= op;
    in_module_index <= INDEX_BITS'(idx);
    in_module_bit   <= dark;
    in_key_frame    <= is_key;
    input_held = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic emit_pixel();
    send_item(OP_EMIT, $urandom_range(0, STORE_DEPTH - 1), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
  endtask

  // stop offering input, wait out every pixel and the tail of any load
  task automatic settle();
    if (input_held) in_valid <= 1'b0;
    input_held = 1'b0;
    // wait on the clock so that the count covers a transaction taken just now
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, with junk above the field now and then
  task automatic write_reg(input cfg_reg_t which, input int value);
    int bits;
    logic [CFG_DATA_BITS-1:0] data, keep;
    case (which)
      REG_FRAME_WIDTH, REG_FRAME_HEIGHT: bits = FRAME_BITS;
      REG_INVERT_COLORS:                 bits = 1;
      REG_CIPHER_MODE:                   bits = 2;
      default:                           bits = 8;
    endcase
    keep = CFG_DATA_BITS'((1 << bits) - 1);
    data = CFG_DATA_BITS'(value) & keep;
    cfg_now[which] = int'(data);
    if ($urandom_range(0, 3) == 0) data = data | (CFG_DATA_BITS'($urandom()) & ~keep);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic end_writes();
    cfg_valid <= 1'b0;
  endtask

  // write each planned register with the given chance in percent
  task automatic write_plan(input int percent);
    for (int i = 0; i < 8; i++) begin
      if ($urandom_range(1, 100) <= percent) write_reg(cfg_reg_t'(i), cfg_plan[i]);
    end
    end_writes();
  endtask

  // pixel side: random stall before each transaction
  initial begin : pixel_sink
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = $urandom_range(0, max_stall);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    int sent, phase, count, frame_px, qr, idx;
    logic is_key;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the low end of both stores; pixel reads and key xors stay inside it
    write_reg(REG_CIPHER_MODE, int'(CIPHER_KEEP));
    end_writes();
    for (int i = 0; i < FILL_DEPTH; i++)
      send_item(OP_LOAD, i, 1'($urandom_range(0, 1)), 1'b1);
    settle();

    // frame, scale, alignment and repeats at their top values, code far wider than the frame
    max_gap   = MAX_WAIT;
    max_stall = MAX_WAIT;
    cfg_plan = '{4095, 4095, 177, 255, 255, 1, int'(CIPHER_OFF), 255};
    write_plan(100);
    repeat (3) emit_pixel();
    settle();

    // zero frame size, zero scale and zero repeats, raster past the new edge
    cfg_plan = '{0, 0, 21, 0, 0, 0, int'(CIPHER_OFF), 0};
    write_plan(100);
    repeat (3) emit_pixel();
    settle();

    // key capture that blanks, key xor, key capture that keeps, mode three, top index
    write_reg(REG_CIPHER_MODE, int'(CIPHER_BLANK));
    end_writes();
    send_item(OP_LOAD, 5, 1'b1, 1'b1);
    settle();
    write_reg(REG_CIPHER_MODE, int'(CIPHER_KEEP));
    end_writes();
    send_item(OP_LOAD, 5, 1'b1, 1'b0);
    send_item(OP_LOAD, 6, 1'b1, 1'b1);
    settle();
    write_reg(REG_CIPHER_MODE, int'(CIPHER_SPARE));
    end_writes();
    send_item(OP_LOAD, 7, 1'b1, 1'b1);
    settle();
    write_reg(REG_CIPHER_MODE, int'(CIPHER_OFF));
    end_writes();
    send_item(OP_LOAD, STORE_DEPTH - 1, 1'b1, 1'b1);
    settle();

    // one alignment step of slack across snaps the x origin to that step; the y slack is under a step
    cfg_plan = '{24, 22, 21, 1, 2, 0, int'(CIPHER_OFF), 2};
    write_plan(100);
    repeat (3) emit_pixel();
    settle();

    // tiny frame repeated twice, ends of line, frame and burst
    cfg_plan = '{3, 2, 21, 2, 0, 1, int'(CIPHER_OFF), 2};
    write_plan(100);
    repeat (12) emit_pixel();

    // random register settings, each followed by a stretch of pixels and loads
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      case ($urandom_range(0, 9))
        0:       cfg_plan[REG_FRAME_WIDTH] = $urandom_range(0, 1) ? 4095 : $urandom_range(0, 1);
        1, 2, 3: cfg_plan[REG_FRAME_WIDTH] = $urandom_range(22, 48);
        default: cfg_plan[REG_FRAME_WIDTH] = $urandom_range(1, 16);
      endcase
      cfg_plan[REG_FRAME_HEIGHT] = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                                               : $urandom_range(1, 8);
      cfg_plan[REG_QR_WIDTH] = ($urandom_range(0, 7) == 0) ? $urandom_range(0, MAX_RAND_QR)
                                                           : $urandom_range(21, MAX_RAND_QR);
      cfg_plan[REG_MODULE_SCALE] = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                               : $urandom_range(0, 3);
      if ($urandom_range(0, 9) == 0)
        cfg_plan[REG_ALIGNMENT] = $urandom_range(0, 255);
      else
        cfg_plan[REG_ALIGNMENT] = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
      cfg_plan[REG_INVERT_COLORS] = $urandom_range(0, 1);
      cfg_plan[REG_CIPHER_MODE]   = $urandom_range(0, 3);
      cfg_plan[REG_FRAME_REPEATS] = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                                : $urandom_range(1, 3);
      write_plan((phase == 0) ? 100 : 50);

      max_gap   = ($urandom_range(0, 4) == 0) ? 0 : MAX_WAIT;
      max_stall = ($urandom_range(0, 4) == 0) ? 0 : MAX_WAIT;

      // as many items as a short burst has pixels, plus up to three; 20 to 80 items otherwise
      frame_px = ((cfg_now[REG_FRAME_WIDTH] == 0) ? 1 : cfg_now[REG_FRAME_WIDTH]) *
                 ((cfg_now[REG_FRAME_HEIGHT] == 0) ? 1 : cfg_now[REG_FRAME_HEIGHT]) *
                 ((cfg_now[REG_FRAME_REPEATS] == 0) ? 1 : cfg_now[REG_FRAME_REPEATS]);
      count = (frame_px <= 160) ? frame_px + $urandom_range(0, 3) : $urandom_range(20, 80);

      for (int i = 0; i < count; i++) begin
        if ($urandom_range(0, 4) == 0) begin
          qr = cfg_now[REG_QR_WIDTH];
          if (cfg_now[REG_CIPHER_MODE] != CIPHER_OFF)
            is_key = ($urandom_range(0, 2) == 0);
          else
            is_key = 1'($urandom_range(0, 1));
          // loads mostly land inside the visible code, key xors inside the filled part
          if (qr != 0 && $urandom_range(0, 3) != 0)
            idx = $urandom_range(0, qr * qr - 1) % STORE_DEPTH;
          else if (cfg_now[REG_CIPHER_MODE] != CIPHER_OFF && !is_key)
            idx = $urandom_range(0, FILL_DEPTH - 1);
          else
            idx = $urandom_range(0, STORE_DEPTH - 1);
          send_item(OP_LOAD, idx, 1'($urandom_range(0, 1)), is_key);
        end else begin
          emit_pixel();
        end
        sent++;
      end
      phase++;
    end

    settle();
    if (mismatches == 0 && outstanding == 0)
      $display("qr_module_raster_scaler_core test passed");
    else
      $display("qr_module_raster_scaler_core test failed");
    $finish;
  end

  // run time guard
  initial begin
    #3000000;
    $display("qr_module_raster_scaler_core test failed");
    $finish;
  end

endmodule

/* files.f */
design/qrs_pkg.sv
design/qrs_div.sv
design/qrs_ctrl.sv
design/qrs_datapath.sv
design/qr_module_raster_scaler_core.sv
verif/qrs_raster_checker.sv
verif/tb.sv
